FILE: rtl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/rrtq_pkg.sv
package rrtq_pkg;

    localparam int MAX_THREADS = 16;
    localparam int TID_W       = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int TYPE_W      = 2;
    localparam int STAT_W      = 2;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_ADMIT  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_SERVE  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [TID_W-1:0]  thread_id;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              served_valid;
        logic [TID_W-1:0]  served_thread;
        logic [CNT_W-1:0]  queue_length;
    } t_rsp;

endpackage

FILE: rtl/round_robin_thread_queue.sv
// Round-robin run queue of thread ids, kept as a circular doubly linked list.
// Request channel (i_req_valid / o_req_ready / i_req): one transaction carries
// req_type (admit, remove, serve next) and thread_id. Response channel
// (o_rsp_valid / i_rsp_ready / o_rsp): exactly one transaction per request,
// with status, the served thread and the queue length after the request.
// The links live in two synchronous memories (next and previous) with a
// registered read; membership bits, head, tail and count are flip-flops.
// A request is taken in the idle state and reads the links at once; the EXEC
// state updates the list registers and the RESP state loads the response.
// An admit to a non-empty queue passes through an extra LINK state between
// EXEC and RESP, since each link memory has a single write port and the admit
// writes two entries in each.
// One request is in flight at a time: the next is taken in the idle state
// that follows the loading of the response register.
// When the receiver stalls, the response is held in the output register and
// the block waits before loading the next one. Reset empties the queue:
// membership, head, tail and count clear; link memories are not cleared.
module round_robin_thread_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  rrtq_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output rrtq_pkg::t_rsp  o_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LINK, S_RESP} t_state;

    t_state                                r_state, n_state;
    rrtq_pkg::t_req                        r_req;
    rrtq_pkg::t_rsp                        r_res, n_res;
    rrtq_pkg::t_rsp                        r_rsp;
    logic                                  r_rsp_valid;
    logic [rrtq_pkg::TID_W-1:0]            r_head, n_head;
    logic [rrtq_pkg::TID_W-1:0]            r_tail, n_tail;
    logic [rrtq_pkg::CNT_W-1:0]            r_count, n_count;
    logic [rrtq_pkg::MAX_THREADS-1:0]      r_in_queue, n_in_queue;

    // Link memories
    logic [rrtq_pkg::TID_W-1:0] r_next_mem [rrtq_pkg::MAX_THREADS];
    logic [rrtq_pkg::TID_W-1:0] r_prev_mem [rrtq_pkg::MAX_THREADS];
    logic [rrtq_pkg::TID_W-1:0] r_next_rd, r_prev_rd;
    logic [rrtq_pkg::TID_W-1:0] rd_addr;
    logic                       next_we, prev_we;
    logic [rrtq_pkg::TID_W-1:0] next_wa, next_wd, prev_wa, prev_wd;

    logic [rrtq_pkg::TID_W-1:0] tid;
    logic                       rsp_free;

    assign tid         = r_req.thread_id;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign rsp_free    = !r_rsp_valid || i_rsp_ready;

    // Read the links of the requested thread, or of the head for serve
    assign rd_addr = (i_req.req_type == rrtq_pkg::REQ_SERVE) ? r_head : i_req.thread_id;

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        r_next_rd <= r_next_mem[rd_addr];
        r_prev_rd <= r_prev_mem[rd_addr];
    end

    // Apply the request to the list and build its response
    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_in_queue = r_in_queue;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        next_wa    = tid;
        next_wd    = tid;
        prev_wa    = tid;
        prev_wd    = tid;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res.status        = rrtq_pkg::ST_IGNORED;
                n_res.served_valid  = 1'b0;
                n_res.served_thread = '0;
                n_state             = S_RESP;
                unique case (r_req.req_type)
                    rrtq_pkg::REQ_ADMIT: begin
                        if (!r_in_queue[tid]) begin
                            n_res.status    = rrtq_pkg::ST_DONE;
                            n_in_queue[tid] = 1'b1;
                            n_count         = r_count + rrtq_pkg::CNT_W'(1);
                            n_tail          = tid;
                            next_we         = 1'b1;
                            prev_we         = 1'b1;
                            if (r_count == '0) begin
                                // Single-entry ring points at itself
                                n_head = tid;
                            end else begin
                                // Hook onto the old tail; close the ring next
                                next_wa = r_tail;
                                prev_wd = r_tail;
                                n_state = S_LINK;
                            end
                        end
                    end
                    rrtq_pkg::REQ_REMOVE: begin
                        if (r_in_queue[tid] && (r_count != '0)) begin
                            n_res.status    = rrtq_pkg::ST_DONE;
                            n_in_queue[tid] = 1'b0;
                            n_count         = r_count - rrtq_pkg::CNT_W'(1);
                            if (r_count == rrtq_pkg::CNT_W'(1)) begin
                                n_head = '0;
                                n_tail = '0;
                            end else begin
                                // Bridge the neighbors over the removed thread
                                next_we = 1'b1;
                                next_wa = r_prev_rd;
                                next_wd = r_next_rd;
                                prev_we = 1'b1;
                                prev_wa = r_next_rd;
                                prev_wd = r_prev_rd;
                                if (tid == r_head) begin
                                    n_head = r_next_rd;
                                end
                                if (tid == r_tail) begin
                                    n_tail = r_prev_rd;
                                end
                            end
                        end
                    end
                    rrtq_pkg::REQ_SERVE: begin
                        if (r_count == '0) begin
                            n_res.status = rrtq_pkg::ST_EMPTY;
                        end else begin
                            // Rotate: head becomes tail, successor becomes head
                            n_res.status        = rrtq_pkg::ST_DONE;
                            n_res.served_valid  = 1'b1;
                            n_res.served_thread = r_head;
                            n_tail              = r_head;
                            n_head              = r_next_rd;
                        end
                    end
                    default: begin
                        n_res.status = rrtq_pkg::ST_IGNORED;
                    end
                endcase
                n_res.queue_length = n_count;
            end
            S_LINK: begin
                // Close the ring between the new tail and the head
                next_we = 1'b1;
                next_wa = tid;
                next_wd = r_head;
                prev_we = 1'b1;
                prev_wa = r_head;
                prev_wd = tid;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (rsp_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, queue registers and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_in_queue  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_in_queue <= n_in_queue;
            if ((r_state == S_RESP) && rsp_free) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
        if ((r_state == S_IDLE) && i_req_valid) begin
            r_req <= i_req;
        end
        r_res <= n_res;
        if ((r_state == S_RESP) && rsp_free) begin
            r_rsp <= r_res;
        end
    end

endmodule

FILE: rtl/rrtq_checker.sv
`include "assert_macros.svh"

module rrtq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input rrtq_pkg::t_req i_req,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input rrtq_pkg::t_rsp o_rsp
);

    logic req_wait;
    logic rsp_stall;
    logic rsp_served;
    logic rsp_empty;
    logic rsp_no_thread;

    assign req_wait      = i_req_valid && !o_req_ready;
    assign rsp_stall     = o_rsp_valid && !i_rsp_ready;
    assign rsp_served    = o_rsp_valid && o_rsp.served_valid;
    assign rsp_empty     = o_rsp_valid && (o_rsp.status == rrtq_pkg::ST_EMPTY);
    assign rsp_no_thread = o_rsp_valid && !o_rsp.served_valid;

    // A waiting request holds
    `ASSERT_NXT(a_req_hold, i_clk, i_rst_n, req_wait, i_req_valid && $stable(i_req))
    // A stalled response holds
    `ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, o_rsp_valid && $stable(o_rsp))
    // A served thread comes only with a done status
    `ASSERT_IMP(a_served_done, i_clk, i_rst_n, rsp_served, o_rsp.status == rrtq_pkg::ST_DONE)
    // An empty report shows an empty queue and no thread
    `ASSERT_IMP(a_empty_len, i_clk, i_rst_n, rsp_empty, !o_rsp.served_valid && !(|o_rsp.queue_length))
    // No thread id without a served thread
    `ASSERT_IMP(a_served_zero, i_clk, i_rst_n, rsp_no_thread, o_rsp.served_thread == '0)

endmodule

bind round_robin_thread_queue rrtq_checker u_rrtq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
